/* hw/rtl/multipole_moment_accumulator_defines.svh */
// Assertion macros for the multipole moment accumulator.
// Every use samples clk and is held off while arst_n is low.
`ifndef MULTIPOLE_MOMENT_ACCUMULATOR_DEFINES_SVH
`define MULTIPOLE_MOMENT_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MMA_ASSERT(lbl, prop, msg)

`define MMA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/mma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

	localparam int MAX_MOMENTS = 16;
	localparam int IDX_W       = $clog2(MAX_MOMENTS);
	localparam int CNT_W       = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CFG_CENTER_REAL  = 2'd0;
	localparam logic [1:0] CFG_CENTER_IMAG  = 2'd1;
	localparam logic [1:0] CFG_MOMENT_COUNT = 2'd2;

	localparam logic signed [47:0] SAT_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] SAT_MIN = {1'b1, {47{1'b0}}};

	typedef struct packed {
		logic signed [31:0] charge;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic               last_source;
	} source_t;

	typedef struct packed {
		logic [3:0]         moment_index;
		logic signed [47:0] moment_real;
		logic signed [47:0] moment_imag;
		logic               last_moment;
	} moment_t;

	typedef struct packed {
		logic signed [31:0] charge;
		logic signed [32:0] d_real;
		logic signed [32:0] d_imag;
		logic [CNT_W-1:0]   count;
		logic               last_source;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COMBINE,
		ST_UPDATE,
		ST_EMIT
	} back_state_t;

	// floor(2^24 / (k+1)), unsigned Q1.24
	function automatic logic [24:0] recip_q24(input logic [IDX_W-1:0] k);
		logic [24:0] r;
		case (k)
			4'd0:    r = 25'd16777216;
			4'd1:    r = 25'd8388608;
			4'd2:    r = 25'd5592405;
			4'd3:    r = 25'd4194304;
			4'd4:    r = 25'd3355443;
			4'd5:    r = 25'd2796202;
			4'd6:    r = 25'd2396745;
			4'd7:    r = 25'd2097152;
			4'd8:    r = 25'd1864135;
			4'd9:    r = 25'd1677721;
			4'd10:   r = 25'd1525201;
			4'd11:   r = 25'd1398101;
			4'd12:   r = 25'd1290555;
			4'd13:   r = 25'd1198372;
			4'd14:   r = 25'd1118481;
			default: r = 25'd1048576;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/mma_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mma_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            source_valid,
	output      logic            source_stall,
	input  wire mma_pkg::source_t source,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [31:0]     cfg_data,
	output      logic            job_valid,
	input  wire logic            job_stall,
	output      mma_pkg::job_t   job
);
	import mma_pkg::*;

	logic signed [31:0] center_real_q;
	logic signed [31:0] center_imag_q;
	logic [CNT_W-1:0]   moment_count_q;
	logic [CNT_W-1:0]   active_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_real_q  <= '0;
			center_imag_q  <= '0;
			moment_count_q <= CNT_W'(MAX_MOMENTS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_REAL:  center_real_q  <= cfg_data;
				CFG_CENTER_IMAG:  center_imag_q  <= cfg_data;
				CFG_MOMENT_COUNT: moment_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (moment_count_q == '0)
			active_count = CNT_W'(1);
		else if (moment_count_q > CNT_W'(MAX_MOMENTS))
			active_count = CNT_W'(MAX_MOMENTS);
		else
			active_count = moment_count_q;
	end

	assign job_valid        = source_valid;
	assign source_stall     = job_stall;
	assign job.charge       = source.charge;
	assign job.d_real       = 33'(source.pos_x) - 33'(center_real_q);
	assign job.d_imag       = 33'(source.pos_y) - 33'(center_imag_q);
	assign job.count        = active_count;
	assign job.last_source  = source.last_source;

endmodule

`default_nettype wire

/* hw/rtl/mma_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "multipole_moment_accumulator_defines.svh"

module mma_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output      logic          push_stall,
	input  wire mma_pkg::job_t push_data,
	output      logic          pop_valid,
	input  wire logic          pop_stall,
	output      mma_pkg::job_t pop_data
);
	import mma_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	job_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign push_stall = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	`MMA_ASSERT(a_fill_bound, (fill_q <= FILL_W'(QUEUE_DEPTH)), "queue fill beyond depth")
	`MMA_ASSERT_NEXT(a_fill_push, (push && !pop), (fill_q == $past(fill_q) + 1'b1), "push lost")

endmodule

`default_nettype wire

/* hw/rtl/mma_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "multipole_moment_accumulator_defines.svh"

module mma_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	output      logic             job_stall,
	input  wire mma_pkg::job_t    job,
	output      logic             moment_valid,
	input  wire logic             moment_stall,
	output      mma_pkg::moment_t moment
);
	import mma_pkg::*;

	function automatic logic signed [47:0] clamp49(input logic signed [48:0] v);
		if (v[48] != v[47])
			return v[48] ? SAT_MIN : SAT_MAX;
		return v[47:0];
	endfunction

	function automatic logic signed [47:0] clamp66(input logic signed [65:0] v);
		if (!v[65] && (|v[64:47]))
			return SAT_MAX;
		if (v[65] && !(&v[64:47]))
			return SAT_MIN;
		return v[47:0];
	endfunction

	function automatic logic signed [47:0] mul_join(input logic signed [57:0] hi,
			input logic signed [57:0] lo);
		logic signed [81:0] full;
		full = {hi, 24'b0} + {{24{lo[57]}}, lo};
		return clamp66(full[81:16]);
	endfunction

	back_state_t        state_q;
	back_state_t        state_d;
	job_t               job_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   e_q;
	logic [MAX_MOMENTS-1:0] vld_q;
	logic signed [47:0] acc_re_q [MAX_MOMENTS];
	logic signed [47:0] acc_im_q [MAX_MOMENTS];
	logic signed [47:0] tr_q;
	logic signed [47:0] ti_q;
	logic signed [32:0] f_re_q;
	logic signed [32:0] f_im_q;
	logic signed [57:0] lo_rr_q, lo_ii_q, lo_ri_q, lo_ir_q;
	logic signed [57:0] hi_rr_q, hi_ii_q, hi_ri_q, hi_ir_q;
	logic signed [47:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
	logic               moment_valid_q;
	moment_t            moment_q;

	logic               take_job;
	logic               acc_we;
	logic               emit_fire;
	logic               step_last;
	logic               emit_last;
	logic [IDX_W-1:0]   rd_idx;
	logic signed [47:0] rd_re;
	logic signed [47:0] rd_im;
	logic [24:0]        recip;
	logic signed [58:0] sc_re;
	logic signed [58:0] sc_im;
	logic signed [24:0] x_re;
	logic signed [24:0] x_im;
	logic signed [57:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [48:0] nr_w;
	logic signed [48:0] ni_w;

	assign step_last = ({1'b0, k_q} == job_q.count - 1'b1);
	assign emit_last = ({1'b0, e_q} == job_q.count - 1'b1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (job_valid) state_d = ST_SCALE;
			ST_SCALE: begin
				if (!step_last)
					state_d = ST_MUL_LO;
				else if (job_q.last_source)
					state_d = ST_EMIT;
				else
					state_d = ST_IDLE;
			end
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_COMBINE;
			ST_COMBINE: state_d = ST_UPDATE;
			ST_UPDATE:  state_d = ST_SCALE;
			ST_EMIT:    if (emit_fire && emit_last) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take_job  = 1'b0;
		acc_we    = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE:  take_job  = job_valid;
			ST_SCALE: acc_we    = 1'b1;
			ST_EMIT:  emit_fire = !moment_valid_q || !moment_stall;
			default: ;
		endcase
	end

	assign job_stall = (state_q != ST_IDLE);

	assign rd_idx = (state_q == ST_EMIT) ? e_q : k_q;
	assign rd_re  = vld_q[rd_idx] ? acc_re_q[rd_idx] : '0;
	assign rd_im  = vld_q[rd_idx] ? acc_im_q[rd_idx] : '0;

	assign recip = recip_q24(k_q);
	assign sc_re = job_q.d_real * $signed({1'b0, recip});
	assign sc_im = job_q.d_imag * $signed({1'b0, recip});

	assign x_re = (state_q == ST_MUL_HI) ? {tr_q[47], tr_q[47:24]} : {1'b0, tr_q[23:0]};
	assign x_im = (state_q == ST_MUL_HI) ? {ti_q[47], ti_q[47:24]} : {1'b0, ti_q[23:0]};
	assign p_rr = x_re * f_re_q;
	assign p_ii = x_im * f_im_q;
	assign p_ri = x_re * f_im_q;
	assign p_ir = x_im * f_re_q;

	assign nr_w = 49'(m_rr_q) - 49'(m_ii_q);
	assign ni_w = 49'(m_ri_q) + 49'(m_ir_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= '0;
			e_q            <= '0;
			vld_q          <= '0;
			moment_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_job)
				k_q <= '0;
			else if (state_q == ST_UPDATE)
				k_q <= k_q + 1'b1;
			if (acc_we)
				vld_q[k_q] <= 1'b1;
			if (emit_fire) begin
				moment_valid_q <= 1'b1;
				e_q            <= emit_last ? '0 : e_q + 1'b1;
				if (emit_last)
					vld_q <= '0;
			end else if (!moment_stall) begin
				moment_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			job_q <= job;
			tr_q  <= 48'(job.charge);
			ti_q  <= '0;
		end
		if (acc_we) begin
			acc_re_q[k_q] <= clamp49(49'(rd_re) + 49'(tr_q));
			acc_im_q[k_q] <= clamp49(49'(rd_im) + 49'(ti_q));
			f_re_q        <= sc_re[56:24];
			f_im_q        <= sc_im[56:24];
		end
		if (state_q == ST_MUL_LO) begin
			lo_rr_q <= p_rr;
			lo_ii_q <= p_ii;
			lo_ri_q <= p_ri;
			lo_ir_q <= p_ir;
		end
		if (state_q == ST_MUL_HI) begin
			hi_rr_q <= p_rr;
			hi_ii_q <= p_ii;
			hi_ri_q <= p_ri;
			hi_ir_q <= p_ir;
		end
		if (state_q == ST_COMBINE) begin
			m_rr_q <= mul_join(hi_rr_q, lo_rr_q);
			m_ii_q <= mul_join(hi_ii_q, lo_ii_q);
			m_ri_q <= mul_join(hi_ri_q, lo_ri_q);
			m_ir_q <= mul_join(hi_ir_q, lo_ir_q);
		end
		if (state_q == ST_UPDATE) begin
			tr_q <= clamp49(nr_w);
			ti_q <= clamp49(ni_w);
		end
		if (emit_fire) begin
			moment_q.moment_index <= e_q;
			moment_q.moment_real  <= rd_re;
			moment_q.moment_imag  <= rd_im;
			moment_q.last_moment  <= emit_last;
		end
	end

	assign moment_valid = moment_valid_q;
	assign moment       = moment_q;

	`MMA_ASSERT(a_step_in_range, (state_q == ST_MUL_LO) |-> ({1'b0, k_q} + 1'b1 < job_q.count), "term step past the moment count")
	`MMA_ASSERT_NEXT(a_update_advance, (state_q == ST_UPDATE), (state_q == ST_SCALE && k_q == $past(k_q) + 1'b1), "series did not advance")
	`MMA_ASSERT_NEXT(a_emit_clears, (emit_fire && emit_last), (state_q == ST_IDLE && vld_q == '0), "store not cleared after last moment")

endmodule

`default_nettype wire

/* hw/rtl/multipole_moment_accumulator.sv */
// Channel   Direction  Handshake                     Payload
// source    in         source_valid / source_stall   charge, pos_x, pos_y, last_source
// moment    out        moment_valid / moment_stall   moment_index, moment_real/imag, last_moment
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// A source walks n orders in the series engine, n being the active moment count;
// each order but the last passes scale, two partial-product passes, join and update.
// A last source then emits n moments, one moment per cycle when moment_stall is low.
// Up to two sources wait in the queue between the front and the series engine.
// arst_n clears control and valid bits; the moment store reads zero with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multipole_moment_accumulator (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             source_valid,
	output      logic             source_stall,
	input  wire mma_pkg::source_t source,
	output      logic             moment_valid,
	input  wire logic             moment_stall,
	output      mma_pkg::moment_t moment,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data
);
	import mma_pkg::*;

	logic job_in_valid;
	logic job_in_stall;
	job_t job_in;
	logic job_out_valid;
	logic job_out_stall;
	job_t job_out;

	mma_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_valid (source_valid),
		.source_stall (source_stall),
		.source       (source),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.job_valid    (job_in_valid),
		.job_stall    (job_in_stall),
		.job          (job_in)
	);

	mma_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_in_valid),
		.push_stall (job_in_stall),
		.push_data  (job_in),
		.pop_valid  (job_out_valid),
		.pop_stall  (job_out_stall),
		.pop_data   (job_out)
	);

	mma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_out_valid),
		.job_stall    (job_out_stall),
		.job          (job_out),
		.moment_valid (moment_valid),
		.moment_stall (moment_stall),
		.moment       (moment)
	);

endmodule

`default_nettype wire
